/* hdl/sfc_pkg.sv */
package sfc_pkg;

  localparam int NUM_SYMBOLS  = 256;
  localparam int MAX_CODE_LEN = 64;
  localparam int COUNT_WIDTH  = 32;

  localparam int IDX_W = 8;
  localparam int NUM_W = 9;
  localparam int SUM_W = COUNT_WIDTH + NUM_W;

  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_BUILD  = 2'd1;
  localparam logic [1:0] OP_LOOKUP = 2'd2;
  localparam logic [1:0] OP_NONE   = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_TOO_LONG  = 2'd2;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  symbol;
    logic [31:0] count;
  } item_t;

  typedef struct packed {
    logic [63:0] code_bits;
    logic [6:0]  code_length;
    logic [1:0]  status;
    logic [8:0]  used_symbols;
  } result_t;

  typedef struct packed {
    logic [7:0]             sym;
    logic [COUNT_WIDTH-1:0] cnt;
  } sorted_t;

  typedef struct packed {
    logic        ovf;
    logic [6:0]  len;
    logic [63:0] word;
  } code_t;

endpackage

/* hdl/shannon_fano_code_builder.sv */
// Shannon-Fano code table builder. An item is taken when start is high and busy is low;
// its one result appears on result for a single cycle with done high, and the receiver
// cannot hold it off. A load gives its result in the cycle after it is taken, a lookup
// after passing through S_L_RD, S_L_POS and S_L_OUT. A build runs a sequencer over
// single-port-read memories: it gathers the counts of all 256 symbols, runs an exchange
// sort of the used symbols, builds the symbol-to-position map, and per split range forms
// the running sums and then appends one bit to the code of each entry in the range.
module shannon_fano_code_builder (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  sfc_pkg::item_t   item,
  output logic             busy,
  output logic             done,
  output sfc_pkg::result_t result
);

  typedef enum logic [4:0] {
    S_IDLE, S_G_RD, S_G_WR, S_SI, S_SIL, S_SJR, S_SJC, S_P, S_PW, S_X_INIT,
    S_X_POP, S_X_E, S_X_A, S_X_AS, S_X_B, S_X_BS, S_X_K, S_X_KW, S_X_PR, S_X_PL,
    S_L_RD, S_L_POS, S_L_OUT
  } state_t;

  localparam int IW = sfc_pkg::IDX_W;
  localparam int NW = sfc_pkg::NUM_W;
  localparam int CW = sfc_pkg::COUNT_WIDTH;
  localparam int SW = sfc_pkg::SUM_W;

  state_t state, state_next;
  sfc_pkg::item_t req, req_next;
  logic [NW-1:0] i, i_next, j, j_next, n, n_next, k, k_next, sp, sp_next;
  logic [NW-1:0] tsize, tsize_next;
  logic [IW-1:0] lo, lo_next, hi, hi_next, a, a_next, b, b_next;
  logic [CW-1:0] ci, ci_next;
  logic [7:0] si, si_next;
  logic [SW-1:0] sum1, sum1_next, sum2, sum2_next;
  logic hit, hit_next;
  logic done_next;
  sfc_pkg::result_t result_next;

  // Count store with reset-cleared valid bits.
  logic [CW-1:0] cnt_mem [sfc_pkg::NUM_SYMBOLS];
  logic cnt_valid [sfc_pkg::NUM_SYMBOLS];
  logic cnt_we;
  logic [IW-1:0] cnt_ra;
  logic [CW-1:0] cnt_rd;
  logic cnt_vrd;

  sfc_pkg::sorted_t srt_mem [sfc_pkg::NUM_SYMBOLS];
  logic srt_we;
  logic [IW-1:0] srt_wa, srt_ra;
  sfc_pkg::sorted_t srt_wd, srt_rd;

  sfc_pkg::code_t code_mem [sfc_pkg::NUM_SYMBOLS];
  logic code_we;
  logic [IW-1:0] code_wa, code_ra;
  sfc_pkg::code_t code_wd, code_rd;

  logic [IW-1:0] pos_mem [sfc_pkg::NUM_SYMBOLS];
  logic pos_we;
  logic [IW-1:0] pos_wa, pos_wd, pos_ra, pos_rd;

  logic [15:0] stk_mem [sfc_pkg::NUM_SYMBOLS];
  logic stk_we;
  logic [IW-1:0] stk_wa, stk_ra;
  logic [15:0] stk_wd, stk_rd;

  logic in_table [sfc_pkg::NUM_SYMBOLS];
  logic tbl_clear, tbl_set;

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[req.symbol] <= req.count[CW-1:0];
    end
    cnt_rd <= cnt_mem[cnt_ra];
    cnt_vrd <= cnt_valid[cnt_ra];
    if (srt_we) begin
      srt_mem[srt_wa] <= srt_wd;
    end
    srt_rd <= srt_mem[srt_ra];
    if (code_we) begin
      code_mem[code_wa] <= code_wd;
    end
    code_rd <= code_mem[code_ra];
    if (pos_we) begin
      pos_mem[pos_wa] <= pos_wd;
    end
    pos_rd <= pos_mem[pos_ra];
    if (stk_we) begin
      stk_mem[stk_wa] <= stk_wd;
    end
    stk_rd <= stk_mem[stk_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int e = 0; e < sfc_pkg::NUM_SYMBOLS; e++) begin
        cnt_valid[e] <= 1'b0;
        in_table[e] <= 1'b0;
      end
    end else begin
      if (cnt_we) begin
        cnt_valid[req.symbol] <= 1'b1;
      end
      // The membership bits are cleared one symbol at a time while the counts are gathered.
      if (tbl_clear) begin
        in_table[cnt_ra] <= 1'b0;
      end else if (tbl_set) begin
        in_table[srt_rd.sym] <= 1'b1;
      end
    end
  end

  always_comb begin
    logic [CW-1:0] gval;
    logic abit;
    state_next = state;
    req_next = req;
    i_next = i; j_next = j; n_next = n; k_next = k; sp_next = sp;
    tsize_next = tsize;
    lo_next = lo; hi_next = hi; a_next = a; b_next = b;
    ci_next = ci; si_next = si; sum1_next = sum1; sum2_next = sum2;
    hit_next = hit;
    done_next = 1'b0;
    result_next = result;
    cnt_we = 1'b0; cnt_ra = i[IW-1:0];
    srt_we = 1'b0; srt_wa = '0; srt_ra = '0; srt_wd = '0;
    code_we = 1'b0; code_wa = '0; code_ra = '0; code_wd = '0;
    pos_we = 1'b0; pos_wa = srt_rd.sym; pos_wd = k[IW-1:0]; pos_ra = req.symbol;
    stk_we = 1'b0; stk_wa = '0; stk_ra = '0; stk_wd = '0;
    tbl_clear = 1'b0; tbl_set = 1'b0;
    gval = cnt_vrd ? cnt_rd : '0;
    abit = ({1'b0, k[IW-1:0]} > {1'b0, b}) || (k > NW'(b));

    case (state)
      S_IDLE: begin
        if (start) begin
          req_next = item;
          case (item.op)
            sfc_pkg::OP_LOAD: begin
              // The write uses req, so it is made while done shows the result.
              state_next = S_IDLE;
            end
            sfc_pkg::OP_BUILD: begin
              i_next = '0;
              n_next = '0;
              state_next = S_G_RD;
            end
            sfc_pkg::OP_LOOKUP: state_next = S_L_RD;
            default: state_next = S_IDLE;
          endcase
          if (item.op != sfc_pkg::OP_BUILD && item.op != sfc_pkg::OP_LOOKUP) begin
            done_next = 1'b1;
            result_next = '0;
            result_next.used_symbols = tsize;
          end
        end
        if (done && req.op == sfc_pkg::OP_LOAD) begin
          cnt_we = 1'b1;
        end
      end
      S_G_RD: begin
        cnt_ra = i[IW-1:0];
        tbl_clear = 1'b1;
        state_next = S_G_WR;
      end
      S_G_WR: begin
        if (gval != '0) begin
          srt_we = 1'b1;
          srt_wa = n[IW-1:0];
          srt_wd.sym = i[IW-1:0];
          srt_wd.cnt = gval;
          code_we = 1'b1;
          code_wa = n[IW-1:0];
          code_wd = '0;
          n_next = n + NW'(1);
        end
        if (i == NW'(sfc_pkg::NUM_SYMBOLS - 1)) begin
          i_next = '0;
          state_next = S_SI;
        end else begin
          i_next = i + NW'(1);
          state_next = S_G_RD;
        end
      end
      S_SI: begin
        tsize_next = n;
        if (i == n) begin
          k_next = '0;
          state_next = S_P;
        end else begin
          srt_ra = i[IW-1:0];
          state_next = S_SIL;
        end
      end
      S_SIL: begin
        ci_next = srt_rd.cnt;
        si_next = srt_rd.sym;
        j_next = '0;
        state_next = S_SJR;
      end
      S_SJR: begin
        if (j == n) begin
          srt_we = 1'b1;
          srt_wa = i[IW-1:0];
          srt_wd.sym = si;
          srt_wd.cnt = ci;
          i_next = i + NW'(1);
          state_next = S_SI;
        end else if (j == i) begin
          j_next = j + NW'(1);
        end else begin
          srt_ra = j[IW-1:0];
          state_next = S_SJC;
        end
      end
      S_SJC: begin
        // Entry i lives in ci/si until its inner pass ends.
        if (srt_rd.cnt < ci) begin
          srt_we = 1'b1;
          srt_wa = j[IW-1:0];
          srt_wd.sym = si;
          srt_wd.cnt = ci;
          ci_next = srt_rd.cnt;
          si_next = srt_rd.sym;
        end
        j_next = j + NW'(1);
        state_next = S_SJR;
      end
      S_P: begin
        if (k == n) begin
          state_next = S_X_INIT;
        end else begin
          srt_ra = k[IW-1:0];
          state_next = S_PW;
        end
      end
      S_PW: begin
        pos_we = 1'b1;
        tbl_set = 1'b1;
        k_next = k + NW'(1);
        state_next = S_P;
      end
      S_X_INIT: begin
        if (n < NW'(2)) begin
          done_next = 1'b1;
          result_next = '0;
          result_next.used_symbols = n;
          state_next = S_IDLE;
        end else begin
          stk_we = 1'b1;
          stk_wa = '0;
          stk_wd = {8'd0, IW'(n - NW'(1))};
          sp_next = NW'(1);
          state_next = S_X_POP;
        end
      end
      S_X_POP: begin
        if (sp == '0) begin
          done_next = 1'b1;
          result_next = '0;
          result_next.used_symbols = tsize;
          state_next = S_IDLE;
        end else begin
          stk_ra = IW'(sp - NW'(1));
          sp_next = sp - NW'(1);
          state_next = S_X_E;
        end
      end
      S_X_E: begin
        lo_next = stk_rd[15:8];
        hi_next = stk_rd[7:0];
        a_next = stk_rd[15:8];
        b_next = stk_rd[7:0];
        sum1_next = '0;
        sum2_next = '0;
        state_next = S_X_A;
      end
      S_X_A: begin
        if (a < b) begin
          srt_ra = a;
          state_next = S_X_AS;
        end else begin
          k_next = {1'b0, lo};
          state_next = S_X_K;
        end
      end
      S_X_AS: begin
        sum1_next = sum1 + SW'(srt_rd.cnt);
        state_next = S_X_B;
      end
      S_X_B: begin
        if (sum2 < sum1 && b > a) begin
          srt_ra = b;
          state_next = S_X_BS;
        end else begin
          a_next = a + IW'(1);
          state_next = S_X_A;
        end
      end
      S_X_BS: begin
        sum2_next = sum2 + SW'(srt_rd.cnt);
        b_next = b - IW'(1);
        state_next = S_X_B;
      end
      S_X_K: begin
        if (k > NW'(hi)) begin
          state_next = S_X_PR;
        end else begin
          code_ra = k[IW-1:0];
          state_next = S_X_KW;
        end
      end
      S_X_KW: begin
        code_we = 1'b1;
        code_wa = k[IW-1:0];
        code_wd = code_rd;
        if (code_rd.len < 7'(sfc_pkg::MAX_CODE_LEN)) begin
          code_wd.word = {code_rd.word[62:0], abit};
          code_wd.len = code_rd.len + 7'd1;
        end else begin
          code_wd.ovf = 1'b1;
        end
        k_next = k + NW'(1);
        state_next = S_X_K;
      end
      S_X_PR: begin
        if ((NW'(b) + NW'(1)) < NW'(hi) && sp < NW'(sfc_pkg::NUM_SYMBOLS)) begin
          stk_we = 1'b1;
          stk_wa = sp[IW-1:0];
          stk_wd = {b + IW'(1), hi};
          sp_next = sp + NW'(1);
        end
        state_next = S_X_PL;
      end
      S_X_PL: begin
        if (lo < b && sp < NW'(sfc_pkg::NUM_SYMBOLS)) begin
          stk_we = 1'b1;
          stk_wa = sp[IW-1:0];
          stk_wd = {lo, b};
          sp_next = sp + NW'(1);
        end
        state_next = S_X_POP;
      end
      S_L_RD: begin
        pos_ra = req.symbol;
        hit_next = in_table[req.symbol];
        state_next = S_L_POS;
      end
      S_L_POS: begin
        code_ra = pos_rd;
        state_next = S_L_OUT;
      end
      S_L_OUT: begin
        done_next = 1'b1;
        result_next = '0;
        result_next.used_symbols = tsize;
        if (hit) begin
          result_next.code_bits = code_rd.word;
          result_next.code_length = code_rd.len;
          result_next.status = code_rd.ovf ? sfc_pkg::ST_TOO_LONG : sfc_pkg::ST_OK;
        end else begin
          result_next.status = sfc_pkg::ST_NOT_FOUND;
        end
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done <= 1'b0;
      tsize <= '0;
      sp <= '0;
      req <= '0;
    end else begin
      state <= state_next;
      done <= done_next;
      tsize <= tsize_next;
      sp <= sp_next;
      req <= req_next;
    end
    result <= result_next;
    i <= i_next; j <= j_next; n <= n_next; k <= k_next;
    lo <= lo_next; hi <= hi_next; a <= a_next; b <= b_next;
    ci <= ci_next; si <= si_next; sum1 <= sum1_next; sum2 <= sum2_next;
    hit <= hit_next;
  end

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while still working");
  a_sp_range: assert property (@(posedge clk) disable iff (rst)
    sp <= NW'(sfc_pkg::NUM_SYMBOLS))
    else $error("range stack overrun");
  a_tsize_range: assert property (@(posedge clk) disable iff (rst)
    tsize <= NW'(sfc_pkg::NUM_SYMBOLS))
    else $error("table size out of range");
  a_no_self_cmp: assert property (@(posedge clk) disable iff (rst)
    (state == S_SJC) |-> (j != i))
    else $error("sort compared an entry with itself");
  a_split_order: assert property (@(posedge clk) disable iff (rst)
    (state == S_X_BS) |=> (b >= a))
    else $error("split pointers crossed");

endmodule
